@@ hdl/pidc_pkg.sv @@
// Shared types, register indexes and constants of the clamped PID controller.
package pidc_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INT_FLOOR = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INT_CEIL  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_FLOOR = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_CEIL  = 3'd6;

    localparam logic FUNC_COMPUTE = 1'b0;
    localparam logic FUNC_CLEAR   = 1'b1;

    typedef struct packed {
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic signed [15:0] integral_floor;
        logic signed [15:0] integral_ceiling;
        logic signed [15:0] output_floor;
        logic signed [15:0] output_ceiling;
    } pidc_cfg_t;

    // Work handed from the front to the back for one compute item.
    typedef struct packed {
        logic signed [16:0] err;
        logic signed [17:0] err_delta;
        logic signed [31:0] err_total;
    } pidc_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pidc_queue_status_t;

endpackage

@@ hdl/pidc_front.sv @@
// Front end: accepts items, forms the error and keeps the error history.
module pidc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_tuser,   // func
    input  logic [31:0]          s_tdata,   // target [15:0], measured [31:16]
    input  logic                 queue_full,
    output logic                 push,
    output pidc_pkg::pidc_item_t push_item
);
    import pidc_pkg::*;

    logic signed [15:0] target;
    logic signed [15:0] measured;
    logic signed [16:0] err;
    logic               hist_clear;
    logic signed [16:0] last_eff;
    logic signed [31:0] total_eff;
    logic signed [32:0] total_sum;
    logic signed [31:0] total_sat;
    logic               accept;

    logic signed [16:0] last_error_reg, last_error_next;
    logic signed [31:0] error_total_reg, error_total_next;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        target     = $signed(s_tdata[15:0]);
        measured   = $signed(s_tdata[31:16]);
        err        = {target[15], target} - {measured[15], measured};
        hist_clear = (err == 17'sd0) && (target == 16'sd0);
        last_eff   = hist_clear ? 17'sd0 : last_error_reg;
        total_eff  = hist_clear ? 32'sd0 : error_total_reg;
        total_sum  = {total_eff[31], total_eff} + {{16{err[16]}}, err};
        if (total_sum[32] != total_sum[31]) begin
            total_sat = total_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            total_sat = total_sum[31:0];
        end

        push_item.err       = err;
        push_item.err_delta = {err[16], err} - {last_eff[16], last_eff};
        push_item.err_total = total_eff;
        push = accept && (s_tuser == FUNC_COMPUTE);

        last_error_next  = last_error_reg;
        error_total_next = error_total_reg;
        if (accept) begin
            if (s_tuser == FUNC_CLEAR) begin
                last_error_next  = 17'sd0;
                error_total_next = 32'sd0;
            end else begin
                last_error_next  = err;
                error_total_next = total_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_error_reg  <= 17'sd0;
            error_total_reg <= 32'sd0;
        end else begin
            last_error_reg  <= last_error_next;
            error_total_reg <= error_total_next;
        end
    end

endmodule

@@ hdl/pidc_queue.sv @@
// Short first-in first-out queue between the front and the back.
module pidc_queue #(
    parameter int DEPTH = pidc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  pidc_pkg::pidc_item_t         push_item,
    input  logic                         pop,
    output pidc_pkg::pidc_item_t         pop_item,
    output pidc_pkg::pidc_queue_status_t status
);
    import pidc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    pidc_item_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign pop_item     = mem_reg[rd_ptr_reg];
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hdl/pidc_back.sv @@
// Back end: gain products, integral clamp, rounding and output clamp.
module pidc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pidc_pkg::pidc_cfg_t  cfg,
    input  logic                 item_valid,
    input  pidc_pkg::pidc_item_t item,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata    // correction
);
    import pidc_pkg::*;

    logic advance;

    logic               a_valid_reg, a_valid_next;
    logic signed [32:0] a_p_reg, a_p_next;
    logic signed [47:0] a_i_reg, a_i_next;
    logic signed [33:0] a_d_reg, a_d_next;

    logic               b_valid_reg, b_valid_next;
    logic signed [32:0] b_p_reg, b_p_next;
    logic signed [23:0] b_i_reg, b_i_next;
    logic signed [33:0] b_d_reg, b_d_next;

    logic               c_valid_reg, c_valid_next;
    logic signed [27:0] c_r_reg, c_r_next;

    logic               out_valid_reg, out_valid_next;
    logic [15:0]        out_data_reg, out_data_next;

    logic signed [47:0] i_lo;
    logic signed [47:0] i_hi;
    logic signed [47:0] i_cl;
    logic signed [35:0] sum;
    logic signed [27:0] o_lo;
    logic signed [27:0] o_hi;
    logic signed [27:0] o_cl;

    assign advance  = !out_valid_reg || m_tready;
    assign pop      = advance && item_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        a_valid_next = item_valid;
        a_p_next     = cfg.gain_p * item.err;
        a_i_next     = cfg.gain_i * item.err_total;
        a_d_next     = cfg.gain_d * item.err_delta;

        i_lo = {{24{cfg.integral_floor[15]}}, cfg.integral_floor, 8'h00};
        i_hi = {{24{cfg.integral_ceiling[15]}}, cfg.integral_ceiling, 8'h00};
        i_cl = (a_i_reg > i_hi) ? i_hi : a_i_reg;
        i_cl = (i_cl < i_lo) ? i_lo : i_cl;
        b_valid_next = a_valid_reg;
        b_p_next     = a_p_reg;
        b_i_next     = i_cl[23:0];
        b_d_next     = a_d_reg;

        sum = {{3{b_p_reg[32]}}, b_p_reg} + {{12{b_i_reg[23]}}, b_i_reg}
            + {{2{b_d_reg[33]}}, b_d_reg} + 36'sd128;
        c_valid_next = b_valid_reg;
        c_r_next     = sum[35:8];

        o_lo = {{12{cfg.output_floor[15]}}, cfg.output_floor};
        o_hi = {{12{cfg.output_ceiling[15]}}, cfg.output_ceiling};
        o_cl = (c_r_reg > o_hi) ? o_hi : c_r_reg;
        o_cl = (o_cl < o_lo) ? o_lo : o_cl;
        out_valid_next = c_valid_reg;
        out_data_next  = o_cl[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            c_valid_reg   <= c_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_p_reg      <= a_p_next;
            a_i_reg      <= a_i_next;
            a_d_reg      <= a_d_next;
            b_p_reg      <= b_p_next;
            b_i_reg      <= b_i_next;
            b_d_reg      <= b_d_next;
            c_r_reg      <= c_r_next;
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ hdl/pid_controller_clamped.sv @@
// Top level of the clamped PID controller: configuration registers and wiring.
//
//   Channel   Direction  Handshake           Payload
//   s_        in         s_tvalid/s_tready   s_tuser func, s_tdata target/measured
//   m_        out        m_tvalid/m_tready   m_tdata correction
//   cfg_      in         cfg_we              cfg_index, cfg_wdata
//
// One item is accepted per cycle while the queue is not full; a compute item yields its
// correction through the queue and a four-register back-end pipeline.
// A clear item updates the error history at acceptance and yields nothing.
// A stalled output freezes the back end; the queue keeps taking items until full.
// Reset is synchronous and active low and restores the register defaults.
module pid_controller_clamped #(
    parameter int QUEUE_DEPTH = pidc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic                             s_tuser,    // func
    input  logic [31:0]                      s_tdata,    // target [15:0], measured [31:16]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,    // correction
    input  logic                             cfg_we,
    input  logic [pidc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import pidc_pkg::*;

    pidc_cfg_t          cfg_reg, cfg_next;
    pidc_item_t         push_item;
    pidc_item_t         pop_item;
    pidc_queue_status_t q_status;
    logic               push;
    logic               pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_GAIN_P:    cfg_next.gain_p           = $signed(cfg_wdata);
                REG_GAIN_I:    cfg_next.gain_i           = $signed(cfg_wdata);
                REG_GAIN_D:    cfg_next.gain_d           = $signed(cfg_wdata);
                REG_INT_FLOOR: cfg_next.integral_floor   = $signed(cfg_wdata);
                REG_INT_CEIL:  cfg_next.integral_ceiling = $signed(cfg_wdata);
                REG_OUT_FLOOR: cfg_next.output_floor     = $signed(cfg_wdata);
                REG_OUT_CEIL:  cfg_next.output_ceiling   = $signed(cfg_wdata);
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p           <= 16'sd0;
            cfg_reg.gain_i           <= 16'sd0;
            cfg_reg.gain_d           <= 16'sd0;
            cfg_reg.integral_floor   <= 16'sh8000;
            cfg_reg.integral_ceiling <= 16'sh7FFF;
            cfg_reg.output_floor     <= 16'sh8000;
            cfg_reg.output_ceiling   <= 16'sh7FFF;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pidc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .queue_full (q_status.full),
        .push       (push),
        .push_item  (push_item)
    );

    pidc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    pidc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (!q_status.empty),
        .item       (pop_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    a_queue_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty at once");

    a_compute_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == FUNC_COMPUTE)) |=> !q_status.empty)
        else $error("accepted compute item did not reach the queue");

endmodule

@@ tb/pid_controller_clamped_check.sv @@
// Checker for the clamped PID controller: tracks settings and history, predicts and compares.
module pid_controller_clamped_check
    import pidc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic                   s_tuser,
    input  logic [31:0]            s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [15:0]            m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int                     mismatches,
    output int                     outstanding
);

    localparam longint SUM_MAX = (longint'(1) << 31) - 1;
    localparam longint SUM_MIN = -(longint'(1) << 31);

    pidc_cfg_t          settings;
    longint             error_sum;
    longint             prev_error;
    logic signed [15:0] corrections_due[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic longint bound(input longint x, input longint lo, input longint hi);
        if (x > hi) x = hi;
        if (x < lo) x = lo;
        return x;
    endfunction

    // Runs one compute item through the controller and updates the history.
    function automatic logic signed [15:0] next_correction(input logic signed [15:0] target,
                                                           input logic signed [15:0] measured);
        longint err;
        longint p_term;
        longint i_term;
        longint d_term;
        longint rounded;
        err = longint'(target) - longint'(measured);
        if (err == 0 && target == 0) begin
            error_sum  = 0;
            prev_error = 0;
        end
        p_term = longint'($signed(settings.gain_p)) * err;
        i_term = bound(longint'($signed(settings.gain_i)) * error_sum,
                       longint'($signed(settings.integral_floor)) * 256,
                       longint'($signed(settings.integral_ceiling)) * 256);
        d_term = longint'($signed(settings.gain_d)) * (err - prev_error);
        rounded = (p_term + i_term + d_term + 128) >>> 8;
        rounded = bound(rounded, longint'($signed(settings.output_floor)),
                        longint'($signed(settings.output_ceiling)));
        prev_error = err;
        error_sum  = bound(error_sum + err, SUM_MIN, SUM_MAX);
        return rounded[15:0];
    endfunction

    task automatic flag_mismatch(input logic signed [15:0] got, input logic signed [15:0] want,
                                 input bit unexpected);
        if (unexpected)
            $display("%0t: correction %0d arrived with no item pending", $time, got);
        else
            $display("%0t: correction %0d, expected %0d", $time, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            settings.gain_p           = '0;
            settings.gain_i           = '0;
            settings.gain_d           = '0;
            settings.integral_floor   = 16'sh8000;
            settings.integral_ceiling = 16'sh7FFF;
            settings.output_floor     = 16'sh8000;
            settings.output_ceiling   = 16'sh7FFF;
            error_sum  = 0;
            prev_error = 0;
            corrections_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_GAIN_P:    settings.gain_p           = cfg_wdata;
                    REG_GAIN_I:    settings.gain_i           = cfg_wdata;
                    REG_GAIN_D:    settings.gain_d           = cfg_wdata;
                    REG_INT_FLOOR: settings.integral_floor   = cfg_wdata;
                    REG_INT_CEIL:  settings.integral_ceiling = cfg_wdata;
                    REG_OUT_FLOOR: settings.output_floor     = cfg_wdata;
                    REG_OUT_CEIL:  settings.output_ceiling   = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == FUNC_CLEAR) begin
                    error_sum  = 0;
                    prev_error = 0;
                end else begin
                    corrections_due.push_back(next_correction(s_tdata[15:0], s_tdata[31:16]));
                end
            end
            if (m_tvalid && m_tready) begin
                if (corrections_due.size() == 0)
                    flag_mismatch(m_tdata, '0, 1'b1);
                else if (m_tdata !== corrections_due[0])
                    flag_mismatch(m_tdata, corrections_due.pop_front(), 1'b0);
                else
                    void'(corrections_due.pop_front());
            end
        end
        outstanding <= corrections_due.size();
    end

endmodule

@@ tb/pid_controller_clamped_test.sv @@
// Top of the clamped PID controller test: clock, reset, stimulus, idling and verdict.
module pid_controller_clamped_test;
    import pidc_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 800000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES = 10;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic                   s_tuser;    // func
    logic [31:0]            s_tdata;    // target [15:0], measured [31:16]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [15:0]            m_tdata;    // correction
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    bit source_gaps = 1'b1;
    bit sink_stalls = 1'b1;

    pid_controller_clamped dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    pid_controller_clamped_check checker_inst (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (sink_stalls && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic func, input logic signed [15:0] target,
                             input logic signed [15:0] measured);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {measured, target};
        do @(posedge aclk); while (!s_tready);
        if (source_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    // Waits until every correction has come out and any clear item has settled.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic load_config(input logic [15:0] gp, input logic [15:0] gi,
                               input logic [15:0] gd, input logic [15:0] int_lo,
                               input logic [15:0] int_hi, input logic [15:0] out_lo,
                               input logic [15:0] out_hi);
        cfg_we <= 1'b1;
        cfg_index <= REG_GAIN_P;    cfg_wdata <= gp;     @(posedge aclk);
        cfg_index <= REG_GAIN_I;    cfg_wdata <= gi;     @(posedge aclk);
        cfg_index <= REG_GAIN_D;    cfg_wdata <= gd;     @(posedge aclk);
        cfg_index <= REG_INT_FLOOR; cfg_wdata <= int_lo; @(posedge aclk);
        cfg_index <= REG_INT_CEIL;  cfg_wdata <= int_hi; @(posedge aclk);
        cfg_index <= REG_OUT_FLOOR; cfg_wdata <= out_lo; @(posedge aclk);
        cfg_index <= REG_OUT_CEIL;  cfg_wdata <= out_hi; @(posedge aclk);
        // Writes to an index past the last register must be ignored.
        cfg_index <= REG_UNUSED;    cfg_wdata <= 16'($urandom); @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] random_gain();
        case ($urandom_range(0, 4))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom);
            default: return 16'($urandom_range(0, 1023) - 512);
        endcase
    endfunction

    task automatic random_bounds(output logic [15:0] lo, output logic [15:0] hi);
        logic signed [15:0] a;
        logic signed [15:0] b;
        a = 16'($urandom);
        b = 16'($urandom);
        case ($urandom_range(0, 4))
            0: begin
                lo = 16'h8000;
                hi = 16'h7FFF;
            end
            1: begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
            2: begin
                lo = a;
                hi = b;
            end
            3: begin
                lo = 16'(-$urandom_range(0, 4000));
                hi = 16'($urandom_range(0, 4000));
            end
            default: begin
                lo = a;
                hi = a;
            end
        endcase
    endtask

    task automatic send_random_item();
        logic signed [15:0] t;
        logic signed [15:0] m;
        t = 16'($urandom);
        m = 16'($urandom);
        case ($urandom_range(0, 19))
            0: send_item(FUNC_CLEAR, t, m);
            1: send_item(FUNC_COMPUTE, 16'sh0000, 16'sh0000);
            2: send_item(FUNC_COMPUTE, t, t);
            3, 4, 5, 6, 7, 8: begin
                t = 16'($urandom_range(0, 2047) - 1024);
                m = t + 16'($urandom_range(0, 255) - 128);
                send_item(FUNC_COMPUTE, t, m);
            end
            default: send_item(FUNC_COMPUTE, t, m);
        endcase
    endtask

    initial begin
        logic [15:0] gp, gi, gd, int_lo, int_hi, out_lo, out_hi;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= FUNC_COMPUTE;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_GAIN_P;
        cfg_wdata <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings first, then directed items at the extremes.
        send_item(FUNC_COMPUTE, 16'sh0300, 16'sh0100);
        send_item(FUNC_COMPUTE, 16'sh7FFF, 16'sh8000);
        wait_drained();
        load_config(16'h0100, 16'h0020, 16'h0080, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_item(FUNC_COMPUTE, 16'sh7FFF, 16'sh8000);
        send_item(FUNC_COMPUTE, 16'sh8000, 16'sh7FFF);
        send_item(FUNC_COMPUTE, 16'sh7FFF, 16'sh8000);
        send_item(FUNC_CLEAR, 16'sh7FFF, 16'sh8000);
        send_item(FUNC_COMPUTE, 16'sh1234, 16'sh1000);
        send_item(FUNC_COMPUTE, 16'sh0100, 16'sh0100);
        send_item(FUNC_COMPUTE, 16'sh0000, 16'sh0000);
        send_item(FUNC_COMPUTE, 16'sh0200, 16'sh0100);
        send_item(FUNC_COMPUTE, -16'sh0080, 16'sh0040);
        wait_drained();
        // Floors above ceilings on both clamps.
        load_config(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0100, 16'hFF00, 16'h0040, 16'hFFC0);
        send_item(FUNC_COMPUTE, 16'sh7FFF, 16'sh8000);
        send_item(FUNC_COMPUTE, 16'sh8000, 16'sh7FFF);
        send_item(FUNC_COMPUTE, 16'sh0000, 16'sh0000);
        send_item(FUNC_COMPUTE, 16'sh0010, 16'sh0000);
        wait_drained();
        load_config(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_item(FUNC_COMPUTE, 16'sh8000, 16'sh7FFF);
        send_item(FUNC_COMPUTE, 16'sh7FFF, 16'sh8000);
        send_item(FUNC_COMPUTE, 16'sh8000, 16'sh8000);
        send_item(FUNC_COMPUTE, 16'shFFFF, 16'sh0001);

        // Random settings, each followed by a batch of random items.
        // The last batch runs without idling on either side.
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            gp = random_gain();
            gi = random_gain();
            gd = random_gain();
            random_bounds(int_lo, int_hi);
            random_bounds(out_lo, out_hi);
            load_config(gp, gi, gd, int_lo, int_hi, out_lo, out_hi);
            source_gaps = (phase < PHASES - 1) && ($urandom_range(0, 3) != 0);
            sink_stalls = (phase < PHASES - 1) && ($urandom_range(0, 3) != 0);
            repeat (125) send_random_item();
        end
        wait_drained();

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
hdl/pidc_pkg.sv
hdl/pidc_front.sv
hdl/pidc_queue.sv
hdl/pidc_back.sv
hdl/pid_controller_clamped.sv
tb/pid_controller_clamped_check.sv
tb/pid_controller_clamped_test.sv
